### hw/rtl/lrupr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants of the LRU page replacement core.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   localparam int CFG_BITS      = 4;
   localparam int FAULT_BITS    = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CFG_BITS-1:0]   FRAME_COUNT_RESET = 4'd4;
   localparam logic [FAULT_BITS-1:0] FAULT_MAX         = 32'hFFFF_FFFF;

   // register index, taken from paddr[2]
   localparam logic REG_FRAME_COUNT = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_UPDATE
   } lrupr_state_type;

   // flags rippled down the cell row during lookup
   typedef struct packed {
      logic hit_seen;
      logic free_seen;
   } lrupr_flags_type;

   // broadcast command from the sequencer to every cell
   typedef struct packed {
      logic look;
      logic apply;
      logic fill;
      logic clear;
   } lrupr_cmd_type;

endpackage

### hw/rtl/lrupr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_req_if
// Page reference channel: valid/ready handshake with one reference per word.
// ----------------------------------------------------------------------------
interface lrupr_req_if #(
   parameter int PAGE_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page;
   logic                 last_ref;

   modport source (output valid, output page, output last_ref, input ready);
   modport sink   (input valid, input page, input last_ref, output ready);
endinterface

### hw/rtl/lrupr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_rsp_if
// Result channel: hit/fault report, evicted page and running fault total.
// ----------------------------------------------------------------------------
interface lrupr_rsp_if #(
   parameter int PAGE_BITS = 16
);
   logic                               valid;
   logic                               ready;
   logic                               hit;
   logic                               evicted_valid;
   logic [PAGE_BITS-1:0]               evicted_page;
   logic [lrupr_pkg::FAULT_BITS-1:0]   fault_total;

   modport source (output valid, output hit, output evicted_valid, output evicted_page,
                   output fault_total, input ready);
   modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                   input fault_total, output ready);
endinterface

### hw/rtl/lrupr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_cell
// One page frame: resident page, valid bit and recency rank, with the
// neighbor links for first-match, first-free, oldest-rank and select ripples.
// ----------------------------------------------------------------------------
module lrupr_cell #(
   parameter int PAGE_BITS = 16,
   parameter int INDEX     = 0,
   parameter int RANK_BITS = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lrupr_pkg::CFG_BITS-1:0]    frame_count,
   input  lrupr_pkg::lrupr_cmd_type          cmd,
   input  logic [PAGE_BITS-1:0]              cmp_page,
   input  lrupr_pkg::lrupr_flags_type        flags_in,
   output lrupr_pkg::lrupr_flags_type        flags_out,
   input  logic [RANK_BITS-1:0]              best_in,
   output logic [RANK_BITS-1:0]              best_out,
   input  logic                              any_hit,
   input  logic                              any_free,
   input  logic [RANK_BITS-1:0]              max_rank,
   input  logic [RANK_BITS-1:0]              old_rank_in,
   output logic [RANK_BITS-1:0]              old_rank_out,
   input  logic [PAGE_BITS-1:0]              ev_page_in,
   output logic [PAGE_BITS-1:0]              ev_page_out,
   input  logic [RANK_BITS-1:0]              old_rank
);

   logic [PAGE_BITS-1:0] page_ff;
   logic                 valid_ff;
   logic [RANK_BITS-1:0] rank_ff;
   logic                 sel_ff;

   logic active;
   logic match;
   logic empty;
   logic pick;

   always_comb begin
      // a zero frame count still leaves frame 0 in use
      active = (INDEX == 0) || (32'(frame_count) > 32'(INDEX));
      match  = active && valid_ff && (page_ff == cmp_page);
      empty  = active && !valid_ff;

      flags_out.hit_seen  = flags_in.hit_seen  | match;
      flags_out.free_seen = flags_in.free_seen | empty;
      best_out = (active && (rank_ff > best_in)) ? rank_ff : best_in;

      if (any_hit) begin
         pick = match && !flags_in.hit_seen;
      end else if (any_free) begin
         pick = empty && !flags_in.free_seen;
      end else begin
         pick = active && (rank_ff == max_rank);
      end

      old_rank_out = old_rank_in | (sel_ff ? rank_ff : '0);
      ev_page_out  = ev_page_in  | (sel_ff ? page_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= RANK_BITS'(INDEX);
         sel_ff   <= 1'b0;
      end else begin
         if (cmd.look) begin
            sel_ff <= pick;
         end else if (cmd.apply) begin
            sel_ff <= 1'b0;
         end
         if (cmd.apply) begin
            if (cmd.clear) begin
               valid_ff <= 1'b0;
               rank_ff  <= RANK_BITS'(INDEX);
            end else if (sel_ff) begin
               valid_ff <= 1'b1;
               rank_ff  <= '0;
            end else if (rank_ff < old_rank) begin
               rank_ff <= rank_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply && !cmd.clear && sel_ff && cmd.fill) begin
         page_ff <= cmp_page;
      end
   end

endmodule

### hw/rtl/lru_page_replacement_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// LRU page replacement over a row of frame cells.
// ----------------------------------------------------------------------------
// Usage:
//  - req_word carries one page reference per word (page, last_ref); rsp_word
//    returns one word per reference: hit, evicted_valid, evicted_page and
//    the saturating fault total of the current reference string.
//  - APB port holds frame_count at byte address 0 (active frames, 0 acts
//    as 1). Write it only while the core is idle. pready is tied high.
//  - An accepted reference passes a lookup state, which ripples match,
//    free and oldest-rank flags through the cell row, then an update state,
//    which ripples the selected rank and page, applies the new ranks and
//    loads the result; the next reference is taken in the update state.
//  - A reference with last_ref set reports normally, then all frames go
//    invalid, ranks return to index order and the fault total to zero.
//  - Reset is synchronous: frames empty, frame_count 4, no result pending.
//  - The result sits in an output register; while the receiver stalls one
//    further reference is looked up, then req_word.ready stays low until
//    the pending result is taken.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   lrupr_req_if.sink                             req_word,
   lrupr_rsp_if.source                           rsp_word,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [lrupr_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [lrupr_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [lrupr_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                  pready
);

   localparam int RANK_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   lrupr_pkg::lrupr_state_type state_ff, state_in;
   lrupr_pkg::lrupr_cmd_type   cmd;

   logic [lrupr_pkg::CFG_BITS-1:0]   frame_count_ff;
   logic [PAGE_BITS-1:0]             page_ff;
   logic                             last_ff;
   logic                             hit_ff;
   logic                             evict_ff;
   logic [lrupr_pkg::FAULT_BITS-1:0] fault_ff;
   logic [lrupr_pkg::FAULT_BITS-1:0] fault_in;

   logic                             rsp_valid_ff;
   logic                             rsp_hit_ff;
   logic                             rsp_ev_valid_ff;
   logic [PAGE_BITS-1:0]             rsp_ev_page_ff;
   logic [lrupr_pkg::FAULT_BITS-1:0] rsp_fault_ff;

   logic req_take;
   logic out_free;
   logic out_load;
   logic csr_wr;

   lrupr_pkg::lrupr_flags_type flags_c [FRAMES+1];
   logic [RANK_BITS-1:0]       best_c  [FRAMES+1];
   logic [RANK_BITS-1:0]       orank_c [FRAMES+1];
   logic [PAGE_BITS-1:0]       evpg_c  [FRAMES+1];

   assign flags_c[0] = '0;
   assign best_c[0]  = '0;
   assign orank_c[0] = '0;
   assign evpg_c[0]  = '0;

   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      lrupr_cell #(
         .PAGE_BITS (PAGE_BITS),
         .INDEX     (g),
         .RANK_BITS (RANK_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .frame_count  (frame_count_ff),
         .cmd          (cmd),
         .cmp_page     (page_ff),
         .flags_in     (flags_c[g]),
         .flags_out    (flags_c[g+1]),
         .best_in      (best_c[g]),
         .best_out     (best_c[g+1]),
         .any_hit      (flags_c[FRAMES].hit_seen),
         .any_free     (flags_c[FRAMES].free_seen),
         .max_rank     (best_c[FRAMES]),
         .old_rank_in  (orank_c[g]),
         .old_rank_out (orank_c[g+1]),
         .ev_page_in   (evpg_c[g]),
         .ev_page_out  (evpg_c[g+1]),
         .old_rank     (orank_c[FRAMES])
      );
   end

   // ---- sequencer ----
   always_comb begin
      out_free       = !rsp_valid_ff || rsp_word.ready;
      state_in       = state_ff;
      req_word.ready = 1'b0;
      out_load       = 1'b0;
      cmd            = '0;
      cmd.fill       = !hit_ff;
      cmd.clear      = last_ff;
      unique case (state_ff)
         lrupr_pkg::ST_IDLE: begin
            req_word.ready = 1'b1;
            if (req_word.valid) begin
               state_in = lrupr_pkg::ST_LOOK;
            end
         end
         lrupr_pkg::ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = lrupr_pkg::ST_UPDATE;
         end
         lrupr_pkg::ST_UPDATE: begin
            if (out_free) begin
               cmd.apply      = 1'b1;
               out_load       = 1'b1;
               req_word.ready = 1'b1;
               state_in       = req_word.valid ? lrupr_pkg::ST_LOOK : lrupr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrupr_pkg::ST_IDLE;
         end
      endcase
      req_take = req_word.valid && req_word.ready;
      if (hit_ff || (fault_ff == lrupr_pkg::FAULT_MAX)) begin
         fault_in = fault_ff;
      end else begin
         fault_in = fault_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrupr_pkg::ST_IDLE;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            fault_ff     <= last_ff ? '0 : fault_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_word.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         page_ff <= req_word.page;
         last_ff <= req_word.last_ref;
      end
      if (cmd.look) begin
         hit_ff   <= flags_c[FRAMES].hit_seen;
         evict_ff <= !flags_c[FRAMES].hit_seen && !flags_c[FRAMES].free_seen;
      end
      if (out_load) begin
         rsp_hit_ff      <= hit_ff;
         rsp_ev_valid_ff <= evict_ff;
         rsp_ev_page_ff  <= evict_ff ? evpg_c[FRAMES] : '0;
         rsp_fault_ff    <= fault_in;
      end
   end

   assign rsp_word.valid         = rsp_valid_ff;
   assign rsp_word.hit           = rsp_hit_ff;
   assign rsp_word.evicted_valid = rsp_ev_valid_ff;
   assign rsp_word.evicted_page  = rsp_ev_page_ff;
   assign rsp_word.fault_total   = rsp_fault_ff;

   // ---- configuration port ----
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= lrupr_pkg::FRAME_COUNT_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            lrupr_pkg::REG_FRAME_COUNT: frame_count_ff <= pwdata[lrupr_pkg::CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         lrupr_pkg::REG_FRAME_COUNT: prdata = lrupr_pkg::CSR_DATA_BITS'(frame_count_ff);
         default: prdata = '0;
      endcase
   end

endmodule

### hw/rtl/lrupr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_checker
// Port-level checks of the LRU page replacement core, bound to the top.
// ----------------------------------------------------------------------------
module lrupr_checker #(
   parameter int PAGE_BITS = 16
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_hit,
   input logic                                 rsp_evicted_valid,
   input logic [PAGE_BITS-1:0]                 rsp_evicted_page,
   input logic [lrupr_pkg::FAULT_BITS-1:0]     rsp_fault_total
);

   // a stalled word keeps its fault total
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fault_total))
      else $error("stalled result word changed");

   // an eviction only happens on a fault
   a_evict_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted_valid))
      else $error("eviction reported on a hit");

   // no eviction means a zero page
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
      else $error("evicted page nonzero without eviction");

   // the lookup state follows each acceptance: no back-to-back acceptance
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("reference accepted during lookup");

endmodule

bind lru_page_replacement_core lrupr_checker #(.PAGE_BITS(PAGE_BITS)) u_lrupr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_word.valid),
   .req_ready         (req_word.ready),
   .rsp_valid         (rsp_word.valid),
   .rsp_ready         (rsp_word.ready),
   .rsp_hit           (rsp_word.hit),
   .rsp_evicted_valid (rsp_word.evicted_valid),
   .rsp_evicted_page  (rsp_word.evicted_page),
   .rsp_fault_total   (rsp_word.fault_total)
);
